### design/fbrpd_pkg.sv
// ----------------------------------------------------------------------------
// fbrpd_pkg
// Shared types, code tables and lookup functions for the five-bit regroup
// prefix decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fbrpd_pkg;

	localparam int SYMBOLS = 32;
	localparam int BUF_W   = 12;
	localparam int CNT_W   = 4;
	localparam int SYM_W   = 5;
	localparam int CODE_W  = 8;
	localparam int NRES_W  = 3;
	localparam logic [NRES_W-1:0] MAX_CHARS = NRES_W'(4);

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_line;
		logic       char_present;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       line_end;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic consume;
		logic clear;
		logic emit_char;
		logic emit_eol;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic next_hit;
		logic out_busy;
	} dp_status_t;

	typedef struct packed {
		logic             hit;
		logic [SYM_W-1:0] sym;
		logic [CNT_W-1:0] len;
	} lookup_t;

	typedef struct packed {
		logic             found;
		logic [SYM_W-1:0] idx;
	} sym_idx_t;

	localparam logic [7:0] ALPHABET [SYMBOLS] = '{
		8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
		8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
		8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
		8'h59, 8'h5A, 8'h20, 8'h2E, 8'h2C, 8'h2D, 8'h27, 8'h3F
	};

	localparam logic [CODE_W-1:0] PC_VALUE [SYMBOLS] = '{
		8'd37,  8'd154, 8'd5,   8'd1,   8'd6,   8'd9,   8'd155, 8'd16,
		8'd7,   8'd152, 8'd6,   8'd4,   8'd153, 8'd158, 8'd5,   8'd7,
		8'd159, 8'd8,   8'd6,   8'd7,   8'd156, 8'd157, 8'd2,   8'd146,
		8'd147, 8'd144, 8'd5,   8'd17,  8'd3,   8'd145, 8'd0,   8'd1
	};

	localparam logic [CNT_W-1:0] PC_LEN [SYMBOLS] = '{
		4'd6, 4'd8, 4'd4, 4'd4, 4'd3, 4'd5, 4'd8, 4'd6,
		4'd4, 4'd8, 4'd4, 4'd5, 4'd8, 4'd8, 4'd5, 4'd3,
		4'd8, 4'd4, 4'd5, 4'd5, 4'd8, 4'd8, 4'd6, 4'd8,
		4'd8, 4'd8, 4'd3, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6
	};

	function automatic sym_idx_t symbol_index(input logic [7:0] ch);
		sym_idx_t r;
		r = '0;
		for (int i = 0; i < SYMBOLS; i++) begin
			if (!r.found && ALPHABET[i] == ch) begin
				r.found = 1'b1;
				r.idx   = SYM_W'(i);
			end
		end
		return r;
	endfunction

	// match the oldest pending bits against the code table
	function automatic lookup_t code_lookup(input logic [BUF_W-1:0] bits,
		input logic [CNT_W-1:0] cnt);
		lookup_t           r;
		logic [BUF_W-1:0]  al;
		logic [CODE_W-1:0] top;
		r   = '0;
		al  = bits << (CNT_W'(BUF_W) - cnt);
		top = al[BUF_W-1 -: CODE_W];
		for (int s = 0; s < SYMBOLS; s++) begin
			if (!r.hit && PC_LEN[s] <= cnt &&
				(top >> (CNT_W'(CODE_W) - PC_LEN[s])) == PC_VALUE[s]) begin
				r.hit = 1'b1;
				r.sym = SYM_W'(s);
				r.len = PC_LEN[s];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/fbrpd_stream_if.sv
// ----------------------------------------------------------------------------
// fbrpd_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbrpd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/fbrpd_dpath.sv
// ----------------------------------------------------------------------------
// fbrpd_dpath
// Bit buffer, code lookup and output beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbrpd_dpath
	import fbrpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire in_item_t   in_item,
	input  wire dp_cmd_t    cmd,
	output dp_status_t      status,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_item_t       out_item
);

	logic [BUF_W-1:0] buf_q;
	logic [CNT_W-1:0] cnt_q;
	out_item_t        out_q;
	logic             out_valid_q;

	lookup_t          lk;
	lookup_t          nx;
	sym_idx_t         si;
	logic [CNT_W-1:0] rem_cnt;
	logic [BUF_W:0]   rem_mask;
	logic [BUF_W-1:0] rem_buf;

	always_comb begin
		lk       = code_lookup(buf_q, cnt_q);
		rem_cnt  = cnt_q - lk.len;
		rem_mask = ((BUF_W+1)'(1) << rem_cnt) - (BUF_W+1)'(1);
		rem_buf  = buf_q & rem_mask[BUF_W-1:0];
		nx       = code_lookup(rem_buf, rem_cnt);
		si       = symbol_index(in_item.char_byte);
	end

	assign status.hit      = lk.hit;
	assign status.next_hit = nx.hit;
	assign status.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
		end else if (cmd.clear) begin
			buf_q <= '0;
			cnt_q <= '0;
		end else if (cmd.consume) begin
			buf_q <= rem_buf;
			cnt_q <= rem_cnt;
		end else if (cmd.load && in_item.char_present && si.found &&
			cnt_q <= CNT_W'(7)) begin
			buf_q <= {buf_q[BUF_W-SYM_W-1:0], si.idx};
			cnt_q <= cnt_q + CNT_W'(SYM_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_char || cmd.emit_eol) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_char) begin
			out_q.out_char    <= ALPHABET[lk.sym];
			out_q.char_valid  <= 1'b1;
			out_q.line_end    <= 1'b0;
			out_q.last_of_run <= cmd.last;
		end else if (cmd.emit_eol) begin
			out_q.out_char    <= '0;
			out_q.char_valid  <= 1'b0;
			out_q.line_end    <= 1'b1;
			out_q.last_of_run <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

### design/fbrpd_ctrl.sv
// ----------------------------------------------------------------------------
// fbrpd_ctrl
// Sequencer: takes an item, then issues one beat per cycle, unless the output is held, until the run ends.
// ----------------------------------------------------------------------------
`default_nettype none

module fbrpd_ctrl
	import fbrpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       in_eol,
	input  wire logic       in_present,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t            state_q;
	logic              eol_q;
	logic              present_q;
	logic [NRES_W-1:0] n_q;
	logic              can_char;
	logic              done;

	assign in_ready = (state_q == S_IDLE);
	assign can_char = present_q && status.hit && (n_q < MAX_CHARS);

	always_comb begin
		cmd  = '0;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_RUN: begin
				if (!can_char && !eol_q) begin
					done = 1'b1;
				end else if (!status.out_busy) begin
					if (can_char) begin
						cmd.emit_char = 1'b1;
						cmd.consume   = 1'b1;
						cmd.last      = !eol_q &&
							!(status.next_hit && (n_q < MAX_CHARS - NRES_W'(1)));
						done          = cmd.last;
					end else begin
						cmd.emit_eol = 1'b1;
						cmd.clear    = 1'b1;
						cmd.last     = 1'b1;
						done         = 1'b1;
					end
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			eol_q     <= 1'b0;
			present_q <= 1'b0;
			n_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q   <= S_RUN;
						eol_q     <= in_eol;
						present_q <= in_present;
						n_q       <= '0;
					end
				end
				S_RUN: begin
					if (cmd.emit_char) begin
						n_q <= n_q + NRES_W'(1);
					end
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### design/five_bit_regroup_prefix_decoder_top.sv
// ----------------------------------------------------------------------------
// five_bit_regroup_prefix_decoder_top
// Regroups alphabet characters into 5-bit indexes and decodes the bit stream
// with a fixed 32-entry prefix code, one decoded character per beat.
// ----------------------------------------------------------------------------
// An input beat is taken while the sequencer is idle; its results then leave
// through the output register at one per cycle while the sink does not hold
// that register. An item causes 0 to 5 results: up to four characters and a
// line end. Each character emitted consumes its code from the bit buffer. The
// next input beat is taken while the last result of the previous item still
// waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module five_bit_regroup_prefix_decoder_top
	import fbrpd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	fbrpd_stream_if.sink   in_ch,
	fbrpd_stream_if.source out_ch
);

	dp_cmd_t    cmd;
	dp_status_t status;
	in_item_t   in_item;
	out_item_t  out_item;

	assign in_item        = in_ch.payload;
	assign out_ch.payload = out_item;

	fbrpd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_eol     (in_item.end_of_line),
		.in_present (in_item.char_present),
		.status     (status),
		.cmd        (cmd)
	);

	fbrpd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

### tb/tb_five_bit_regroup_prefix_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_five_bit_regroup_prefix_decoder_top
// Self-checking bench for the five-bit regroup prefix decoder. A scoreboard
// keeps its own bit buffer, regroups each accepted character into 5 bits and
// decodes the buffer against the 32-entry prefix code. Every output beat is
// compared field by field with the oldest predicted result. Directed lines
// cover the alphabet ends, foreign bytes and empty line ends. Random lines
// follow, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------

module tb_five_bit_regroup_prefix_decoder_top;
	import fbrpd_pkg::*;

	localparam int    CYCLE_LIMIT  = 200000;
	localparam int    RANDOM_ITEMS = 470;
	localparam int    CALM_FROM    = 400;
	localparam string LETTERS      = "ABCDEFGHIJKLMNOPQRSTUVWXYZ .,-'?";

	localparam logic [7:0] CODE_BITS [32] = '{
		8'd37,  8'd154, 8'd5,   8'd1,   8'd6,   8'd9,   8'd155, 8'd16,
		8'd7,   8'd152, 8'd6,   8'd4,   8'd153, 8'd158, 8'd5,   8'd7,
		8'd159, 8'd8,   8'd6,   8'd7,   8'd156, 8'd157, 8'd2,   8'd146,
		8'd147, 8'd144, 8'd5,   8'd17,  8'd3,   8'd145, 8'd0,   8'd1
	};
	localparam logic [3:0] CODE_LEN [32] = '{
		4'd6, 4'd8, 4'd4, 4'd4, 4'd3, 4'd5, 4'd8, 4'd6,
		4'd4, 4'd8, 4'd4, 4'd5, 4'd8, 4'd8, 4'd5, 4'd3,
		4'd8, 4'd4, 4'd5, 4'd5, 4'd8, 4'd8, 4'd6, 4'd8,
		4'd8, 4'd8, 4'd3, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6
	};

	class char_decode_model;
		logic [11:0] held_bits;
		logic [3:0]  held_cnt;
		out_item_t   pending_chars [$];
		int          errors;

		function new();
			held_bits = '0;
			held_cnt  = '0;
			errors    = 0;
		endfunction

		function void absorb_char(in_item_t it);
			int        idx;
			int        hit_sym;
			int        n;
			out_item_t r;
			idx = -1;
			n   = 0;
			if (it.char_present) begin
				for (int i = 0; i < 32; i++)
					if (idx < 0 && LETTERS[i] == it.char_byte)
						idx = i;
				if (idx >= 0 && held_cnt <= 4'd7) begin
					held_bits = (held_bits << 5) | 12'(idx);
					held_cnt  = held_cnt + 4'd5;
				end
				forever begin
					hit_sym = -1;
					for (int s = 0; s < 32; s++)
						if (hit_sym < 0 && CODE_LEN[s] <= held_cnt &&
							(held_bits >> (held_cnt - CODE_LEN[s])) == 12'(CODE_BITS[s]))
							hit_sym = s;
					if (hit_sym < 0 || n >= 4)
						break;
					held_cnt  = held_cnt - CODE_LEN[hit_sym];
					held_bits = held_bits & ((12'd1 << held_cnt) - 12'd1);
					r = '{out_char: LETTERS[hit_sym], char_valid: 1'b1,
						line_end: 1'b0, last_of_run: 1'b0};
					pending_chars = {pending_chars, r};
					n++;
				end
			end
			if (it.end_of_line) begin
				held_bits = '0;
				held_cnt  = '0;
				r = '{out_char: 8'h00, char_valid: 1'b0, line_end: 1'b1, last_of_run: 1'b0};
				pending_chars = {pending_chars, r};
				n++;
			end
			if (n > 0)
				pending_chars[pending_chars.size() - 1].last_of_run = 1'b1;
		endfunction

		function void check_char(out_item_t got);
			out_item_t want;
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected beat char=%h valid=%b eol=%b last=%b", $time,
					got.out_char, got.char_valid, got.line_end, got.last_of_run);
				errors++;
				return;
			end
			want = pending_chars.pop_front();
			if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
				got.line_end !== want.line_end || got.last_of_run !== want.last_of_run) begin
				$display("%0t: mismatch expected char=%h valid=%b eol=%b last=%b", $time,
					want.out_char, want.char_valid, want.line_end, want.last_of_run);
				$display("%0t:          actual   char=%h valid=%b eol=%b last=%b", $time,
					got.out_char, got.char_valid, got.line_end, got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic calm;
	int   cycles;
	int   sent;

	char_decode_model decoder = new();

	fbrpd_stream_if #(.payload_t(in_item_t))  in_ch ();
	fbrpd_stream_if #(.payload_t(out_item_t)) out_ch ();

	five_bit_regroup_prefix_decoder_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (in_ch.valid && in_ch.ready)
			decoder.absorb_char(in_ch.payload);
		if (out_ch.valid && out_ch.ready)
			decoder.check_char(out_ch.payload);
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// sink side: random stall bursts until the calm tail
	initial begin
		int stall_left;
		stall_left   = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ch.ready = 1'b0;
				stall_left   = $urandom_range(1, 15) - 1;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	task automatic send_beat(input logic [7:0] ch, input logic eol, input logic present);
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_ch.valid   = 1'b1;
		in_ch.payload = '{char_byte: ch, end_of_line: eol, char_present: present};
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	task automatic send_random_line();
		int        line_len;
		int        pick;
		logic [7:0] ch;
		line_len = $urandom_range(1, 12);
		for (int k = 0; k < line_len; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				ch = LETTERS[$urandom_range(0, 31)];
				send_beat(ch, 1'b0, 1'b1);
			end else if (pick < 93) begin
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			end else begin
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
		end
		pick = $urandom_range(0, 9);
		if (pick == 0)
			send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
		else if (pick == 1)
			send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		else
			send_beat(LETTERS[$urandom_range(0, 31)], 1'b1, 1'b1);
	endtask

	initial begin
		cycles        = 0;
		sent          = 0;
		calm          = 1'b0;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_beat(8'h41, 1'b0, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat("A", 1'b0, 1'b1);
		send_beat("Z", 1'b0, 1'b1);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hFF, 1'b0, 1'b1);
		send_beat(" ", 1'b0, 1'b1);
		send_beat(".", 1'b0, 1'b1);
		send_beat("a", 1'b0, 1'b1);
		send_beat(",", 1'b0, 1'b1);
		send_beat("-", 1'b0, 1'b1);
		send_beat("'", 1'b0, 1'b1);
		send_beat("?", 1'b1, 1'b1);
		send_beat("E", 1'b0, 1'b1);
		send_beat("P", 1'b0, 1'b1);
		send_beat(8'h41, 1'b1, 1'b0);
		send_beat("?", 1'b0, 1'b1);
		send_beat("?", 1'b0, 1'b1);
		send_beat("?", 1'b0, 1'b1);
		send_beat(8'h80, 1'b1, 1'b1);
		send_beat(8'h7F, 1'b0, 1'b1);
		send_beat("'", 1'b0, 1'b1);
		send_beat("'", 1'b1, 1'b1);

		while (sent < RANDOM_ITEMS) begin
			if (sent >= CALM_FROM)
				calm = 1'b1;
			send_random_line();
		end
		@(negedge clk);
		in_ch.valid = 1'b0;
		calm        = 1'b1;

		while (decoder.pending_chars.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (decoder.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
